[rtl/core/assert_macros.svh]
// Assertion macros of the SHA-1 hasher, included by its top level.
// Bodies fall away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk_i while rst_ni is high.
`define SHA1_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sha1 assertion failed");
// Check prop at every rising edge of clk_i, reset included.
`define SHA1_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sha1 assertion failed");
`else
`define SHA1_ASSERT(lbl, prop)
`define SHA1_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/sha1_pkg.sv]
// Types and constants of the SHA-1 hasher: command and status structs,
// round constants and the initial vector. No dependencies.
`default_nettype none

package sha1_pkg;

  typedef enum logic [1:0] {
    SRC_MSG   = 2'd0,
    SRC_PAD80 = 2'd1,
    SRC_ZERO  = 2'd2,
    SRC_LEN   = 2'd3
  } byte_src_e;

  localparam logic [2:0] LAST_WORD = 3'd4;

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [31:0] INIT_H [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Controller to datapath.
  typedef struct packed {
    logic      wr_byte;      // write one byte at the fill position
    byte_src_e byte_sel;     // where that byte comes from
    logic      count_byte;   // advance the message byte count
    logic      load_rounds;  // load a..e from the chaining value
    logic      round_en;     // run one compression round
    logic [1:0] round_phase; // which group of twenty rounds
    logic      add_chain;    // fold a..e into the chaining value
    logic      finish;       // back to the initial vector, clear counts
    logic [2:0] out_sel;     // digest word on the output
  } sha1_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fill_last;     // next byte fills the block
    logic fill_pad_end;  // fill position has reached the length field
  } sha1_sts_t;

endpackage

`default_nettype wire

[rtl/core/sha1_if.sv]
// Valid/ready channel interfaces of the SHA-1 hasher: byte requests in,
// digest words out. No dependencies.
`default_nettype none

interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       carries_byte;
  logic       end_of_message;

  modport source (output valid, msg_byte, carries_byte, end_of_message, input ready);
  modport sink   (input valid, msg_byte, carries_byte, end_of_message, output ready);
endinterface

interface sha1_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_position;
  logic        final_word;

  modport source (output valid, digest_word, word_position, final_word, input ready);
  modport sink   (input valid, digest_word, word_position, final_word, output ready);
endinterface

`default_nettype wire

[rtl/core/sha1_byte_stream_hasher.sv]
// SHA-1 byte-stream hasher, top level. Depends on sha1_pkg, sha1_if,
// sha1_ctrl, sha1_dp and assert_macros.svh.
// Byte requests are taken back to back while idle; the 64th byte of a block
// starts a compression (80 rounds, then the chaining add) that holds off
// requests. An end request adds padding, one or two compressions, five words.
// Reset (async, active low): chaining value to IV, counters and control zero.
`default_nettype none

`include "assert_macros.svh"

module sha1_byte_stream_hasher (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sha1_req_if.sink   req_i,
  sha1_dig_if.source dig_o
);
  import sha1_pkg::*;

  sha1_cmd_t   cmd;
  sha1_sts_t   sts;
  logic [31:0] digest_word;

  // Controller: owns the handshakes, the padding sequence and the round
  // counter; the datapath only obeys the command struct.
  sha1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .carries_i   (req_i.carries_byte),
    .end_i       (req_i.end_of_message),
    .req_ready_o (req_i.ready),
    .dig_valid_o (dig_o.valid),
    .dig_ready_i (dig_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: block window, round registers, chaining value and counts.
  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (req_i.msg_byte),
    .sts_o         (sts),
    .digest_word_o (digest_word)
  );

  // Digest words come straight from the chaining registers, which hold
  // still while the output is stalled.
  assign dig_o.digest_word   = digest_word;
  assign dig_o.word_position = cmd.out_sel;
  assign dig_o.final_word    = (cmd.out_sel == LAST_WORD);

  // Never take a request while a digest word is on offer.
  `SHA1_ASSERT(a_no_overlap, !(req_i.ready && dig_o.valid))
  // A byte that fills the block must start a compression.
  `SHA1_ASSERT(a_full_starts, (cmd.wr_byte && sts.fill_last) |-> cmd.load_rounds)
  // After the last digest word goes, requests are taken again.
  `SHA1_ASSERT(a_back_idle,
    (dig_o.valid && dig_o.ready && dig_o.final_word) |=> req_i.ready)
  // Digest word index stays in range while offered.
  `SHA1_ASSERT(a_pos_range,
    dig_o.valid |-> (dig_o.word_position <= LAST_WORD))

endmodule

`default_nettype wire

[rtl/core/sha1_dp.sv]
// SHA-1 datapath: block store / schedule window, round registers, chaining
// value, byte and fill counters. Depends on sha1_pkg.
`default_nettype none

module sha1_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sha1_pkg::sha1_cmd_t cmd_i,
  input  wire logic [7:0]        msg_byte_i,
  output sha1_pkg::sha1_sts_t    sts_o,
  output logic [31:0]            digest_word_o
);
  import sha1_pkg::*;

  // One 16-word window serves as block store while filling and as the
  // rolling schedule while compressing; each word is rewritten by its first
  // byte before it is read again.
  logic [3:0][7:0] sched_q [16];
  logic [31:0]     chain_q [5];
  logic [31:0]     a_q, b_q, c_q, d_q, e_q;
  logic [5:0]      fill_q;
  logic [60:0]     total_q;

  logic [7:0][7:0] len_bytes;
  logic [7:0]      byte_val;
  logic [31:0]     w_next, f_val, t_val;

  assign len_bytes = {total_q, 3'b000};

  always_comb begin
    unique case (cmd_i.byte_sel)
      SRC_MSG:   byte_val = msg_byte_i;
      SRC_PAD80: byte_val = PAD_MARK;
      SRC_ZERO:  byte_val = 8'h00;
      SRC_LEN:   byte_val = len_bytes[~fill_q[2:0]];
      default:   byte_val = 8'h00;
    endcase
  end

  assign w_next = {sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0]};

  always_comb begin
    unique case (cmd_i.round_phase)
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd2:    f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default: f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + sched_q[0]
               + ROUND_K[cmd_i.round_phase];

  // Window: byte writes while filling, shift while compressing.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      if (fill_q[1:0] == 2'd0) begin
        sched_q[fill_q[5:2]] <= {byte_val, 24'h000000};
      end else begin
        sched_q[fill_q[5:2]][~fill_q[1:0]] <= byte_val;
      end
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[15] <= {w_next[30:0], w_next[31]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= INIT_H[i];
      end
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      e_q     <= '0;
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.wr_byte) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.count_byte) begin
        total_q <= total_q + 61'd1;
      end
      if (cmd_i.load_rounds) begin
        a_q <= chain_q[0];
        b_q <= chain_q[1];
        c_q <= chain_q[2];
        d_q <= chain_q[3];
        e_q <= chain_q[4];
      end else if (cmd_i.round_en) begin
        a_q <= t_val;
        b_q <= a_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        d_q <= c_q;
        e_q <= d_q;
      end
      if (cmd_i.add_chain) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end else if (cmd_i.finish) begin
        for (int i = 0; i < 5; i++) begin
          chain_q[i] <= INIT_H[i];
        end
        total_q <= '0;
        fill_q  <= '0;
      end
    end
  end

  assign sts_o.fill_last    = (fill_q == 6'd63);
  assign sts_o.fill_pad_end = (fill_q == 6'd56);

  always_comb begin
    unique case (cmd_i.out_sel)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      3'd4:    digest_word_o = chain_q[4];
      default: digest_word_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/sha1_ctrl.sv]
// SHA-1 controller: sequences byte intake, padding, the 80 rounds and the
// digest output. Depends on sha1_pkg.
`default_nettype none

module sha1_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  input  wire logic            carries_i,
  input  wire logic            end_i,
  output logic                 req_ready_o,
  output logic                 dig_valid_o,
  input  wire logic            dig_ready_i,
  input  wire sha1_pkg::sha1_sts_t sts_i,
  output sha1_pkg::sha1_cmd_t  cmd_o
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD80  = 3'd1;
  localparam logic [2:0] S_PADZ   = 3'd2;
  localparam logic [2:0] S_PADLEN = 3'd3;
  localparam logic [2:0] S_COMP   = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic [1:0] phase_q, phase_d;
  logic [4:0] cnt_q, cnt_d;
  logic [2:0] pos_q, pos_d;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    cmd_o   = '0;
    cmd_o.byte_sel    = SRC_MSG;
    cmd_o.round_phase = phase_q;
    cmd_o.out_sel     = pos_q;
    req_ready_o = 1'b0;
    dig_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (carries_i) begin
            cmd_o.wr_byte    = 1'b1;
            cmd_o.count_byte = 1'b1;
          end
          if (carries_i && sts_i.fill_last) begin
            cmd_o.load_rounds = 1'b1;
            state_d = S_COMP;
            ret_d   = end_i ? S_PAD80 : S_IDLE;
          end else if (end_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_sel = SRC_PAD80;
        if (sts_i.fill_last) begin
          cmd_o.load_rounds = 1'b1;
          state_d = S_COMP;
          ret_d   = S_PADZ;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts_i.fill_pad_end) begin
          state_d = S_PADLEN;
        end else begin
          cmd_o.wr_byte  = 1'b1;
          cmd_o.byte_sel = SRC_ZERO;
          if (sts_i.fill_last) begin
            cmd_o.load_rounds = 1'b1;
            state_d = S_COMP;
            ret_d   = S_PADZ;
          end
        end
      end
      S_PADLEN: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_sel = SRC_LEN;
        if (sts_i.fill_last) begin
          cmd_o.load_rounds = 1'b1;
          state_d = S_COMP;
          ret_d   = S_OUT;
        end
      end
      S_COMP: begin
        cmd_o.round_en = 1'b1;
        if (cnt_q == 5'd19) begin
          cnt_d   = '0;
          phase_d = phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            state_d = S_ADD;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_ADD: begin
        cmd_o.add_chain = 1'b1;
        state_d = ret_q;
      end
      S_OUT: begin
        dig_valid_o = 1'b1;
        if (dig_ready_i) begin
          if (pos_q == LAST_WORD) begin
            cmd_o.finish = 1'b1;
            pos_d   = '0;
            state_d = S_IDLE;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      phase_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

[tb/sha1_byte_stream_hasher_tb.sv]
// Self-checking testbench of sha1_byte_stream_hasher: byte requests in, digest
// words out, each word checked against a SHA-1 model held in a scoreboard.
// Depends on sha1_pkg, sha1_if and the RTL of the hasher.
module sha1_byte_stream_hasher_tb;
  import sha1_pkg::*;

  // Cycles with no handshake on either side before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles watched after the last digest word, to catch stray words.
  localparam int DRAIN_CYCLES = 300;
  // Length of the one long hold-off on the digest side.
  localparam int SINK_HOLD_CYCLES = 600;
  // Requests to send over the whole run, idle ones included.
  localparam int TOTAL_ITEMS = 180;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  position;
    logic        last;
  } digest_word_t;

  // Tracks the hash of the message in flight and the digest words owed.
  class sha1_digest_board;
    logic [31:0]  chain_h [5];
    logic [31:0]  block_words [16];
    logic [5:0]   fill_slot;
    logic [60:0]  byte_count;
    digest_word_t words_due [$];
    int           mismatches;

    function new();
      chain_h = INIT_H;
      foreach (block_words[i]) block_words[i] = '0;
      fill_slot = '0;
      byte_count = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, t;
      int r;
      sched = block_words;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (r = 0; r < 80; r++) begin
        if (r >= 16)
          sched[r & 15] = rotl(sched[(r - 3) & 15] ^ sched[(r - 8) & 15]
                               ^ sched[(r - 14) & 15] ^ sched[r & 15], 1);
        if (r < 20) f = (b & c) | (~b & d);
        else if (r < 40 || r >= 60) f = b ^ c ^ d;
        else f = (b & c) | (b & d) | (c & d);
        t = rotl(a, 5) + f + e + sched[r & 15] + ROUND_K[r / 20];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
    endfunction

    // Pack one byte big-endian; the 64th byte of a block compresses it.
    function void absorb_byte(logic [7:0] value);
      logic [31:0] w;
      int sh;
      sh = 8 * (3 - int'(fill_slot[1:0]));
      w = (fill_slot[1:0] == 2'd0) ? 32'h0 : block_words[fill_slot[5:2]];
      w[sh +: 8] = value;
      block_words[fill_slot[5:2]] = w;
      fill_slot++;
      if (fill_slot == 6'd0) compress_block();
    endfunction

    function void note_request(logic [7:0] value, logic carries, logic ends);
      logic [63:0]  bit_len;
      digest_word_t dw;
      int k;
      if (carries) begin
        absorb_byte(value);
        byte_count++;
      end
      if (!ends) return;
      bit_len = {byte_count, 3'b000};
      absorb_byte(PAD_MARK);
      while (fill_slot != 6'd56) absorb_byte(8'h00);
      for (k = 7; k >= 0; k--) absorb_byte(bit_len[8 * k +: 8]);
      for (k = 0; k < 5; k++) begin
        dw.word = chain_h[k];
        dw.position = 3'(k);
        dw.last = (3'(k) == LAST_WORD);
        words_due.push_back(dw);
      end
      chain_h = INIT_H;
      byte_count = '0;
      fill_slot = '0;
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", what);
    endtask

    task check_word(logic [31:0] word, logic [2:0] position, logic last);
      digest_word_t due;
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("digest word %h at position %0d with none due",
                                  word, position));
        return;
      end
      due = words_due.pop_front();
      if (word !== due.word)
        report_mismatch($sformatf("word %0d: got %h, want %h",
                                  due.position, word, due.word));
      if (position !== due.position)
        report_mismatch($sformatf("position: got %0d, want %0d", position, due.position));
      if (last !== due.last)
        report_mismatch($sformatf("final flag at position %0d: got %b, want %b",
                                  due.position, last, due.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sha1_req_if req ();
  sha1_dig_if dig ();

  sha1_byte_stream_hasher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .dig_o  (dig)
  );

  sha1_digest_board board;

  // While calm is set pick_gap gives neither side a gap; the stimulus sets it anew per message.
  bit calm;
  // Raised by the stimulus to ask the digest side for its long hold-off.
  bit sink_hold_request;
  // Requests accepted so far, idle ones included.
  int items_sent;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Message lengths: the padding boundaries first, then mostly short ones
  // with a fair share of lengths around the spill into an extra block.
  function automatic int pick_length(int index);
    if (index == 0) return 56;
    if (index == 1) return 64;
    if (index == 2) return 55;
    if ($urandom_range(9) < 4) begin
      case ($urandom_range(7))
        0: return 0;
        1: return 1;
        2: return 55;
        3: return 56;
        4: return 57;
        5: return 63;
        6: return 64;
        default: return 65;
      endcase
    end
    return $urandom_range(20);
  endfunction

  // Offer one request, hold it until taken, then note it and maybe idle.
  // Leave valid high when no gap follows, so the next request goes straight on.
  task automatic send_request(logic [7:0] value, logic carries, logic ends);
    int gap;
    req.valid          <= 1'b1;
    req.msg_byte       <= value;
    req.carries_byte   <= carries;
    req.end_of_message <= ends;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(value, carries, ends);
    items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send a whole message of random bytes with idle requests mixed in; the
  // last byte rides on the end request about half the time.
  task automatic send_message(int length);
    bit byte_on_end;
    int n;
    byte_on_end = (length != 0) && ($urandom_range(1) == 1);
    for (n = 0; n < length - int'(byte_on_end); n++) begin
      if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, 1'b0);
    end
    send_request(8'($urandom), byte_on_end, 1'b1);
  endtask

  // Digest side: check every accepted word, then pick the next stall.
  initial begin : digest_sink
    int stall_left;
    stall_left = 0;
    dig.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (dig.valid && dig.ready)
        board.check_word(dig.digest_word, dig.word_position, dig.final_word);
      if (stall_left != 0) begin
        stall_left--;
      end else if (sink_hold_request) begin
        // Hold off long enough for the hasher to fill up and stall its input.
        sink_hold_request = 1'b0;
        stall_left = SINK_HOLD_CYCLES;
      end else begin
        stall_left = pick_gap();
      end
      dig.ready <= (stall_left == 0);
    end
  end

  // Abandon the run when neither side has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (dig.valid && dig.ready)) quiet = 0;
      else quiet++;
    end
    $display("sha1_byte_stream_hasher_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int msg_count;
    int msg_len;
    board = new();
    calm = 1'b0;
    sink_hold_request = 1'b0;
    items_sent = 0;
    rst_ni             <= 1'b0;
    req.valid          <= 1'b0;
    req.msg_byte       <= 8'h00;
    req.carries_byte   <= 1'b0;
    req.end_of_message <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message: an end request carrying no byte, straight after reset.
    send_request(8'h00, 1'b0, 1'b1);
    // Idle request with every byte bit set: must leave the hash untouched.
    send_request(8'hFF, 1'b0, 1'b0);
    // Classic "abc", with the last byte riding on the end request.
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // Extreme byte values, an idle request in between, end without a byte
    // but with a stray value on the byte field.
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7F, 1'b0, 1'b1);
    // One-byte message sent as a lone end request.
    send_request(8'h5A, 1'b1, 1'b1);
    // Two empty messages back to back.
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);

    // Random messages; the third one triggers the long hold-off downstream.
    msg_count = 0;
    while (items_sent < TOTAL_ITEMS) begin
      calm = ($urandom_range(3) == 0);
      if (msg_count == 2) sink_hold_request = 1'b1;
      // Trim the message so the run stays close to the request budget.
      msg_len = pick_length(msg_count);
      if (msg_len > TOTAL_ITEMS - items_sent - 1) msg_len = TOTAL_ITEMS - items_sent - 1;
      send_message(msg_len);
      msg_count++;
    end
    calm = 1'b0;
    if (req.valid) req.valid <= 1'b0;

    // Drain every digest word owed, then watch for strays a while longer.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("sha1_byte_stream_hasher_tb OK");
    else
      $display("sha1_byte_stream_hasher_tb NOT OK");
    $finish;
  end

endmodule
